[rtl/firmware_image_tlv_parser_top_defines.svh]
// Assertion macros for the image parser.
// Both expect clk and rst_n in the scope of use.
`ifndef FIRMWARE_IMAGE_TLV_PARSER_TOP_DEFINES_SVH
`define FIRMWARE_IMAGE_TLV_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define FWTLV_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FWTLV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fwtlv_pkg.sv]
`default_nettype none
package fwtlv_pkg;

    localparam int HEADER_BYTES   = 32;
    localparam int HASH_BYTES_DEF = 32;
    localparam int RES_DEPTH      = 4;

    localparam logic [31:0] IMG_MAGIC  = 32'h96f3_b83d;
    localparam logic [15:0] INFO_MAGIC = 16'h6907;
    localparam logic [7:0]  SHA_TYPE   = 8'h10;
    localparam logic [31:0] SEG_START_MAX = 32'hFFFF_FFFC;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_HDR_MAGIC,
        ST_BAD_TLV_MAGIC,
        ST_BAD_HASH_LEN,
        ST_TRUNCATED,
        ST_BAD_LAYOUT
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_INFO,
        PH_ENTRY,
        PH_DATA
    } phase_t;

    typedef enum logic {
        KIND_HASH,
        KIND_FINAL
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  hash_byte;
        logic [4:0]  hash_index;
        status_t     status;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [15:0] version_revision;
        logic [31:0] build_number;
        logic [31:0] image_size;
        logic [31:0] total_size;
        logic        run_last;
    } res_t;

    // a_v: first record valid, b_v: second record valid
    typedef struct packed {
        logic a_v;
        logic b_v;
    } push_t;

    typedef struct packed {
        logic [31:0] byte_offset;
        phase_t      phase;
        logic [31:0] field_shift;
        logic [15:0] header_length;
        logic [31:0] body_length;
        logic [63:0] version_store;
        logic [31:0] tlv_area_end;
        logic [7:0]  entry_type;
        logic [31:0] entry_end;
        logic        finished;
    } state_t;

    localparam state_t STATE_RESET = '{
        byte_offset:   32'd0,
        phase:         PH_HEADER,
        field_shift:   32'd0,
        header_length: 16'd0,
        body_length:   32'd0,
        version_store: 64'd0,
        tlv_area_end:  32'd0,
        entry_type:    8'd0,
        entry_end:     32'd0,
        finished:      1'b0
    };

endpackage
`default_nettype wire

[rtl/fwtlv_in_if.sv]
`default_nettype none
interface fwtlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       last_byte;

    modport source (output valid, output file_byte, output last_byte, input ready);
    modport sink (input valid, input file_byte, input last_byte, output ready);
endinterface
`default_nettype wire

[rtl/fwtlv_out_if.sv]
`default_nettype none
interface fwtlv_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  hash_byte;
    logic [4:0]  hash_index;
    logic [2:0]  status;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [15:0] version_revision;
    logic [31:0] build_number;
    logic [31:0] image_size;
    logic [31:0] total_size;
    logic        run_last;

    modport source (
        output valid, output kind, output hash_byte, output hash_index, output status,
        output version_major, output version_minor, output version_revision,
        output build_number, output image_size, output total_size, output run_last,
        input ready
    );
    modport sink (
        input valid, input kind, input hash_byte, input hash_index, input status,
        input version_major, input version_minor, input version_revision,
        input build_number, input image_size, input total_size, input run_last,
        output ready
    );
endinterface
`default_nettype wire

[rtl/fwtlv_parser.sv]
`default_nettype none
`include "firmware_image_tlv_parser_top_defines.svh"
module fwtlv_parser #(
    parameter int HASH_BYTES = fwtlv_pkg::HASH_BYTES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      file_byte,
    input  wire logic            last_byte,
    output fwtlv_pkg::push_t     push,
    output fwtlv_pkg::res_t      res_a,
    output fwtlv_pkg::res_t      res_b
);

    fwtlv_pkg::state_t  st_reg;
    fwtlv_pkg::state_t  st_next;
    fwtlv_pkg::state_t  st_p;

    logic [31:0]        off;
    logic [1:0]         k;
    logic [15:0]        byte16;
    logic [31:0]        byte32;
    logic [63:0]        byte64;

    logic               done;
    logic               trunc;
    logic               final_v;
    logic               hash_v;
    fwtlv_pkg::status_t fin_status;
    logic [31:0]        fin_total;
    logic [31:0]        idx_full;
    logic [32:0]        info_sum;
    logic [32:0]        area_end;
    logic [32:0]        ent_end;
    logic               seg_open;
    fwtlv_pkg::phase_t  seg_phase;
    logic [31:0]        seg_start;
    logic               walk;
    logic [31:0]        walk_cur;

    fwtlv_pkg::res_t    hash_rec;
    fwtlv_pkg::res_t    fin_rec;

    assign off    = st_reg.byte_offset;
    assign k      = st_reg.byte_offset[1:0] - st_reg.entry_end[1:0];
    assign byte16 = {8'd0, file_byte};
    assign byte32 = {24'd0, file_byte};
    assign byte64 = {56'd0, file_byte};

    always_comb
    begin
        st_p       = st_reg;
        done       = 1'b0;
        fin_status = fwtlv_pkg::ST_OK;
        fin_total  = 32'd0;
        hash_v     = 1'b0;
        idx_full   = 32'd0;
        info_sum   = 33'd0;
        area_end   = 33'd0;
        ent_end    = 33'd0;
        seg_open   = 1'b0;
        seg_phase  = fwtlv_pkg::PH_INFO;
        seg_start  = 32'd0;
        walk       = 1'b0;
        walk_cur   = 32'd0;

        if (!st_reg.finished)
        begin
            st_p.byte_offset = off + 32'd1;
            case (st_reg.phase)
                fwtlv_pkg::PH_HEADER:
                begin
                    if (off <= 32'd3)
                    begin
                        st_p.field_shift = st_reg.field_shift | (byte32 << {off[1:0], 3'b000});
                        if (off == 32'd3 && st_p.field_shift != fwtlv_pkg::IMG_MAGIC)
                        begin
                            done       = 1'b1;
                            fin_status = fwtlv_pkg::ST_BAD_HDR_MAGIC;
                        end
                    end
                    else if (off == 32'd8 || off == 32'd9)
                    begin
                        st_p.header_length = st_reg.header_length
                                           | (byte16 << {off[0], 3'b000});
                    end
                    else if (off >= 32'd12 && off <= 32'd15)
                    begin
                        st_p.body_length = st_reg.body_length | (byte32 << {off[1:0], 3'b000});
                    end
                    else if (off >= 32'd20 && off <= 32'd27)
                    begin
                        st_p.version_store = st_reg.version_store
                                           | (byte64 << {off[2:0] ^ 3'b100, 3'b000});
                    end
                    if (!done && off == 32'(fwtlv_pkg::HEADER_BYTES - 1))
                    begin
                        info_sum = {17'd0, st_p.header_length} + {1'b0, st_p.body_length};
                        if (info_sum < 33'(fwtlv_pkg::HEADER_BYTES) || info_sum[32])
                        begin
                            done       = 1'b1;
                            fin_status = fwtlv_pkg::ST_BAD_LAYOUT;
                        end
                        else if (info_sum == 33'(fwtlv_pkg::HEADER_BYTES))
                        begin
                            seg_open  = 1'b1;
                            seg_phase = fwtlv_pkg::PH_INFO;
                            seg_start = info_sum[31:0];
                        end
                        else
                        begin
                            st_p.phase     = fwtlv_pkg::PH_SKIP;
                            st_p.entry_end = info_sum[31:0];
                        end
                    end
                end
                fwtlv_pkg::PH_SKIP:
                begin
                    if ({1'b0, off} + 33'd1 == {1'b0, st_reg.entry_end})
                    begin
                        seg_open  = 1'b1;
                        seg_phase = fwtlv_pkg::PH_INFO;
                        seg_start = st_reg.entry_end;
                    end
                end
                fwtlv_pkg::PH_INFO:
                begin
                    st_p.field_shift = st_reg.field_shift | (byte32 << {k, 3'b000});
                    if (k == 2'd3)
                    begin
                        area_end = {1'b0, st_reg.entry_end} - 33'd4
                                 + {17'd0, st_p.field_shift[31:16]};
                        if (st_p.field_shift[15:0] != fwtlv_pkg::INFO_MAGIC)
                        begin
                            done       = 1'b1;
                            fin_status = fwtlv_pkg::ST_BAD_TLV_MAGIC;
                        end
                        else if (area_end[32])
                        begin
                            done       = 1'b1;
                            fin_status = fwtlv_pkg::ST_BAD_LAYOUT;
                        end
                        else
                        begin
                            st_p.tlv_area_end = area_end[31:0];
                            walk              = 1'b1;
                            walk_cur          = st_reg.entry_end;
                        end
                    end
                end
                fwtlv_pkg::PH_ENTRY:
                begin
                    if (k == 2'd0)
                    begin
                        st_p.entry_type = file_byte;
                    end
                    else if (k[1])
                    begin
                        st_p.field_shift = st_reg.field_shift | (byte32 << {k[0], 3'b000});
                    end
                    if (k == 2'd3)
                    begin
                        ent_end = {1'b0, st_reg.entry_end} + {17'd0, st_p.field_shift[15:0]};
                        if (ent_end[32])
                        begin
                            done       = 1'b1;
                            fin_status = fwtlv_pkg::ST_BAD_LAYOUT;
                        end
                        else if (st_p.entry_type == fwtlv_pkg::SHA_TYPE
                                 && st_p.field_shift[15:0] != 16'(HASH_BYTES))
                        begin
                            done       = 1'b1;
                            fin_status = fwtlv_pkg::ST_BAD_HASH_LEN;
                        end
                        else if (st_p.field_shift[15:0] == 16'd0)
                        begin
                            walk     = 1'b1;
                            walk_cur = st_reg.entry_end;
                        end
                        else
                        begin
                            st_p.phase     = fwtlv_pkg::PH_DATA;
                            st_p.entry_end = ent_end[31:0];
                        end
                    end
                end
                fwtlv_pkg::PH_DATA:
                begin
                    if (st_reg.entry_type == fwtlv_pkg::SHA_TYPE)
                    begin
                        hash_v   = 1'b1;
                        idx_full = 32'(HASH_BYTES) - st_reg.entry_end + off;
                    end
                    if ({1'b0, off} + 33'd1 == {1'b0, st_reg.entry_end})
                    begin
                        walk     = 1'b1;
                        walk_cur = st_reg.entry_end;
                    end
                end
                default:
                begin
                    st_p.phase = fwtlv_pkg::PH_HEADER;
                end
            endcase

            // end of TLV area reached, or start of the next entry header
            if (walk)
            begin
                if (walk_cur >= st_p.tlv_area_end)
                begin
                    done       = 1'b1;
                    fin_status = fwtlv_pkg::ST_OK;
                    fin_total  = walk_cur;
                end
                else
                begin
                    seg_open  = 1'b1;
                    seg_phase = fwtlv_pkg::PH_ENTRY;
                    seg_start = walk_cur;
                end
            end

            if (seg_open)
            begin
                if (seg_start > fwtlv_pkg::SEG_START_MAX)
                begin
                    done       = 1'b1;
                    fin_status = fwtlv_pkg::ST_BAD_LAYOUT;
                end
                else
                begin
                    st_p.phase       = seg_phase;
                    st_p.field_shift = 32'd0;
                    st_p.entry_end   = seg_start + 32'd4;
                end
            end

            if (done)
            begin
                st_p.finished = 1'b1;
            end
        end
    end

    assign trunc   = last_byte && !st_reg.finished && !done;
    assign final_v = done || trunc;

    always_comb
    begin
        hash_rec            = '0;
        hash_rec.kind       = fwtlv_pkg::KIND_HASH;
        hash_rec.hash_byte  = file_byte;
        hash_rec.hash_index = idx_full[4:0];
        hash_rec.status     = fwtlv_pkg::ST_OK;
        hash_rec.run_last   = !final_v;

        fin_rec                  = '0;
        fin_rec.kind             = fwtlv_pkg::KIND_FINAL;
        fin_rec.status           = trunc ? fwtlv_pkg::ST_TRUNCATED : fin_status;
        fin_rec.version_major    = st_p.version_store[7:0];
        fin_rec.version_minor    = st_p.version_store[15:8];
        fin_rec.version_revision = st_p.version_store[31:16];
        fin_rec.build_number     = st_p.version_store[63:32];
        fin_rec.image_size       = st_p.body_length;
        fin_rec.total_size       = trunc ? 32'd0 : fin_total;
        fin_rec.run_last         = 1'b1;
    end

    always_comb
    begin
        push.a_v = accept && (hash_v || final_v);
        push.b_v = accept && hash_v && final_v;
        res_a    = hash_v ? hash_rec : fin_rec;
        res_b    = fin_rec;
    end

    assign st_next = last_byte ? fwtlv_pkg::STATE_RESET : st_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= fwtlv_pkg::STATE_RESET;
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

    `FWTLV_ASSERT_HOLD(a_quiet_after_final, accept && st_reg.finished, !push.a_v, "result after final status")
    `FWTLV_ASSERT_NEXT(a_final_sticks, accept && final_v && !last_byte, st_reg.finished, "parser not halted after final status")
    `FWTLV_ASSERT_HOLD(a_hash_in_sha_data, hash_v && !st_reg.finished, st_reg.phase == fwtlv_pkg::PH_DATA && st_reg.entry_type == fwtlv_pkg::SHA_TYPE, "hash beat outside SHA data")

endmodule
`default_nettype wire

[rtl/fwtlv_res_fifo.sv]
`default_nettype none
`include "firmware_image_tlv_parser_top_defines.svh"
module fwtlv_res_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fwtlv_pkg::push_t push,
    input  wire fwtlv_pkg::res_t din_a,
    input  wire fwtlv_pkg::res_t din_b,
    input  wire logic            pop,
    output fwtlv_pkg::res_t      dout,
    output logic                 out_valid,
    output logic                 room
);

    localparam int PTR_W = $clog2(fwtlv_pkg::RES_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    fwtlv_pkg::res_t  mem [fwtlv_pkg::RES_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] wr_plus;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] n_push;

    assign wr_plus   = wr_reg + PTR_W'(1);
    assign n_push    = CNT_W'(push.a_v) + CNT_W'(push.b_v);
    assign wr_next   = wr_reg + n_push[PTR_W-1:0];
    assign rd_next   = pop ? rd_reg + PTR_W'(1) : rd_reg;
    assign count_next = count_reg + n_push - CNT_W'(pop);

    assign dout      = mem[rd_reg];
    assign out_valid = (count_reg != CNT_W'(0));
    assign room      = (count_reg <= CNT_W'(fwtlv_pkg::RES_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.a_v)
        begin
            mem[wr_reg] <= din_a;
        end
        if (push.b_v)
        begin
            mem[wr_plus] <= din_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `FWTLV_ASSERT_HOLD(a_cnt_bound, 1'b1, count_reg <= CNT_W'(fwtlv_pkg::RES_DEPTH), "result buffer overflow")
    `FWTLV_ASSERT_HOLD(a_pair_order, push.b_v, push.a_v, "second record without first")
    `FWTLV_ASSERT_NEXT(a_pop_drains, pop && !push.a_v, count_reg == $past(count_reg) - CNT_W'(1), "pop did not drain one beat")

endmodule
`default_nettype wire

[rtl/firmware_image_tlv_parser_top.sv]
// A result beat is registered in the result buffer when its byte is taken on img, and offered on res from its head.
// One byte per cycle is taken while img.ready is high; a byte that yields two results gives two beats on res.
// img.ready falls while fewer than two slots of the four-beat result buffer are free.
// Reset (rst_n low, asynchronous): header phase, offset zero, result buffer empty.
// A final status halts parsing until a byte marked last_byte rearms it.
`default_nettype none
module firmware_image_tlv_parser_top #(
    parameter int HASH_BYTES = fwtlv_pkg::HASH_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fwtlv_in_if.sink    img,
    fwtlv_out_if.source res
);

    logic              accept;
    logic              pop;
    logic              room;
    logic              out_valid;
    fwtlv_pkg::push_t  push;
    fwtlv_pkg::res_t   res_a;
    fwtlv_pkg::res_t   res_b;
    fwtlv_pkg::res_t   head;

    assign img.ready = room;
    assign accept    = img.valid && room;
    assign pop       = out_valid && res.ready;

    fwtlv_parser #(
        .HASH_BYTES (HASH_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .file_byte (img.file_byte),
        .last_byte (img.last_byte),
        .push      (push),
        .res_a     (res_a),
        .res_b     (res_b)
    );

    fwtlv_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din_a     (res_a),
        .din_b     (res_b),
        .pop       (pop),
        .dout      (head),
        .out_valid (out_valid),
        .room      (room)
    );

    assign res.valid            = out_valid;
    assign res.kind             = head.kind;
    assign res.hash_byte        = head.hash_byte;
    assign res.hash_index       = head.hash_index;
    assign res.status           = head.status;
    assign res.version_major    = head.version_major;
    assign res.version_minor    = head.version_minor;
    assign res.version_revision = head.version_revision;
    assign res.build_number     = head.build_number;
    assign res.image_size       = head.image_size;
    assign res.total_size       = head.total_size;
    assign res.run_last         = head.run_last;

endmodule
`default_nettype wire

[bench/firmware_image_tlv_parser_top_tb.sv]
`timescale 1ns / 1ps
module firmware_image_tlv_parser_top_tb;
    import fwtlv_pkg::*;

    localparam int HASH_LEN    = HASH_BYTES_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_BYTES  = 450;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } img_beat_t;

    typedef enum int {
        IMG_OK,
        IMG_SHORT_AREA,
        IMG_BAD_HDR,
        IMG_BAD_TLV,
        IMG_BAD_LEN,
        IMG_LOW_OFFSET,
        IMG_OVERFLOW,
        IMG_TRUNCATED,
        IMG_ODD_AREA,
        IMG_SHAPES
    } img_shape_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fwtlv_in_if  img ();
    fwtlv_out_if res ();

    firmware_image_tlv_parser_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .img   (img),
        .res   (res)
    );

    always #5 clk = ~clk;

    img_beat_t  pending[$];
    logic [7:0] img_q[$];
    res_t       results_due[$];
    res_t       step_q[$];

    int   errors      = 0;
    int   taken       = 0;
    int   seen        = 0;
    int   quiet       = 0;
    int   hold_left   = 0;
    int   holds_spare = 2;
    logic calm        = 1'b0;

    // parser model state
    logic [31:0] img_offset;
    phase_t      phase;
    logic [31:0] acc;
    logic [15:0] hdr_len;
    logic [31:0] body_len;
    logic [63:0] ver;
    logic [31:0] area_end;
    logic [7:0]  ent_type;
    logic [31:0] seg_end;
    logic        halted;

    task automatic clear_model();
        img_offset = '0;
        phase      = PH_HEADER;
        acc        = '0;
        hdr_len    = '0;
        body_len   = '0;
        ver        = '0;
        area_end   = '0;
        ent_type   = '0;
        seg_end    = '0;
        halted     = 1'b0;
    endtask

    task automatic emit_final(input status_t st, input logic [31:0] total);
        res_t r;
        r = '0;
        r.kind             = KIND_FINAL;
        r.status           = st;
        r.version_major    = ver[7:0];
        r.version_minor    = ver[15:8];
        r.version_revision = ver[31:16];
        r.build_number     = ver[63:32];
        r.image_size       = body_len;
        r.total_size       = total;
        step_q.push_back(r);
        halted = 1'b1;
    endtask

    task automatic emit_hash(input logic [7:0] b, input logic [4:0] idx);
        res_t r;
        r = '0;
        r.kind       = KIND_HASH;
        r.hash_byte  = b;
        r.hash_index = idx;
        step_q.push_back(r);
    endtask

    task automatic open_seg(input phase_t ph, input logic [63:0] start);
        if (start + 64'd4 > 64'h1_0000_0000)
            emit_final(ST_BAD_LAYOUT, '0);
        else
        begin
            phase   = ph;
            acc     = '0;
            seg_end = start[31:0] + 32'd4;
        end
    endtask

    task automatic next_ent(input logic [31:0] c);
        if (c >= area_end)
            emit_final(ST_OK, c);
        else
            open_seg(PH_ENTRY, 64'(c));
    endtask

    task automatic header_byte(input logic [7:0] b);
        logic [31:0] o;
        logic [63:0] info;
        o = img_offset;
        if (o <= 3)
        begin
            acc |= 32'(b) << (8 * o);
            if (o == 3 && acc != IMG_MAGIC)
                emit_final(ST_BAD_HDR_MAGIC, '0);
        end
        else if (o == 8 || o == 9)
            hdr_len |= 16'(b) << (8 * (o - 8));
        else if (o >= 12 && o <= 15)
            body_len |= 32'(b) << (8 * (o - 12));
        else if (o >= 20 && o <= 27)
            ver |= 64'(b) << (8 * (o - 20));
        if (!halted && o == HEADER_BYTES - 1)
        begin
            info = 64'(hdr_len) + 64'(body_len);
            if (info < HEADER_BYTES || info > 64'hFFFF_FFFF)
                emit_final(ST_BAD_LAYOUT, '0);
            else if (info == HEADER_BYTES)
                open_seg(PH_INFO, info);
            else
            begin
                phase   = PH_SKIP;
                seg_end = info[31:0];
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [1:0]  k;
        logic [63:0] w;
        logic [15:0] len;
        logic [31:0] idx;
        res_t        r;
        step_q.delete();
        if (!halted)
        begin
            k = 2'(img_offset - seg_end);
            case (phase)
                PH_HEADER: header_byte(b);
                PH_SKIP:
                    if (33'(img_offset) + 33'd1 == 33'(seg_end))
                        open_seg(PH_INFO, 64'(seg_end));
                PH_INFO:
                begin
                    acc |= 32'(b) << (8 * k);
                    if (k == 2'd3)
                    begin
                        w = 64'(seg_end) - 64'd4 + 64'(acc[31:16]);
                        if (acc[15:0] != INFO_MAGIC)
                            emit_final(ST_BAD_TLV_MAGIC, '0);
                        else if (w > 64'hFFFF_FFFF)
                            emit_final(ST_BAD_LAYOUT, '0);
                        else
                        begin
                            area_end = w[31:0];
                            next_ent(seg_end);
                        end
                    end
                end
                PH_ENTRY:
                begin
                    if (k == 2'd0)
                        ent_type = b;
                    else if (k >= 2'd2)
                        acc |= 32'(b) << (8 * (k - 2'd2));
                    if (k == 2'd3)
                    begin
                        len = acc[15:0];
                        w   = 64'(seg_end) + 64'(len);
                        if (w > 64'hFFFF_FFFF)
                            emit_final(ST_BAD_LAYOUT, '0);
                        else if (ent_type == SHA_TYPE && len != HASH_LEN)
                            emit_final(ST_BAD_HASH_LEN, '0);
                        else if (len == 16'd0)
                            next_ent(seg_end);
                        else
                        begin
                            phase   = PH_DATA;
                            seg_end = w[31:0];
                        end
                    end
                end
                default:
                begin
                    if (ent_type == SHA_TYPE)
                    begin
                        idx = HASH_LEN - (seg_end - img_offset);
                        emit_hash(b, idx[4:0]);
                    end
                    if (33'(img_offset) + 33'd1 == 33'(seg_end))
                        next_ent(seg_end);
                end
            endcase
            img_offset++;
        end
        if (last)
        begin
            if (!halted)
                emit_final(ST_TRUNCATED, '0);
            clear_model();
        end
        if (step_q.size() > 0)
        begin
            r = step_q.pop_back();
            r.run_last = 1'b1;
            step_q.push_back(r);
        end
        foreach (step_q[i])
            results_due.push_back(step_q[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic push_beat(input logic [7:0] d, input logic l);
        img_beat_t t;
        t.data = d;
        t.last = l;
        pending.push_back(t);
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            img_q.push_back(v[8*i +: 8]);
    endtask

    task automatic put_rand(input int n);
        repeat (n) img_q.push_back(8'($urandom));
    endtask

    task automatic build_image(input img_shape_t shape);
        logic [15:0] hlen;
        logic [31:0] blen;
        logic [31:0] magic;
        logic [63:0] vbits;
        logic [15:0] area;
        logic [15:0] tlv_magic;
        logic [15:0] elen;
        logic [7:0]  etype;
        int          n_ent;
        int          info_pos;
        int          cut;
        bit          sha_used;
        img_q.delete();
        hlen = 16'd32;
        if ($urandom_range(0, 3) == 0)
            hlen = 16'(32 + $urandom_range(0, 6));
        blen = $urandom_range(0, 10);
        case ($urandom_range(0, 3))
            0: vbits = '0;
            1: vbits = '1;
            default: vbits = {$urandom, $urandom};
        endcase
        magic = IMG_MAGIC;
        if (shape == IMG_BAD_HDR)
            magic = magic ^ (32'd1 << $urandom_range(0, 31));
        if (shape == IMG_LOW_OFFSET)
        begin
            hlen = 16'($urandom_range(0, 31));
            blen = $urandom_range(0, 31 - hlen);
        end
        if (shape == IMG_OVERFLOW)
        begin
            hlen = 16'($urandom_range(1, 65535));
            blen = 32'hFFFF_FFFF - $urandom_range(0, hlen - 1);
            if ($urandom_range(0, 1) == 0)
            begin
                hlen = 16'hFFFF;
                blen = 32'hFFFF_FFFF;
            end
        end

        put_le(magic, 4);
        put_rand(4);
        put_le(32'(hlen), 2);
        put_rand(2);
        put_le(blen, 4);
        put_rand(4);
        put_le(vbits[31:0], 4);
        put_le(vbits[63:32], 4);
        put_rand(4);

        if (shape != IMG_BAD_HDR && shape != IMG_LOW_OFFSET && shape != IMG_OVERFLOW)
        begin
            put_rand(hlen + blen - 32);
            tlv_magic = INFO_MAGIC;
            if (shape == IMG_BAD_TLV)
                tlv_magic = tlv_magic ^ (16'd1 << $urandom_range(0, 15));
            info_pos = img_q.size();
            put_le(32'(tlv_magic), 2);
            put_le(32'd0, 2);
            n_ent = (shape == IMG_SHORT_AREA) ? 0 : $urandom_range(0, 3);
            if (shape == IMG_BAD_LEN && n_ent == 0)
                n_ent = 1;
            sha_used = 1'b0;
            for (int e = 0; e < n_ent; e++)
            begin
                if (shape == IMG_BAD_LEN && e == n_ent - 1)
                begin
                    etype = SHA_TYPE;
                    if ($urandom_range(0, 1) == 0)
                        elen = 16'($urandom_range(0, HASH_LEN - 1));
                    else
                        elen = 16'($urandom_range(HASH_LEN + 1, 65535));
                end
                else if (!sha_used && $urandom_range(0, 1) == 1)
                begin
                    etype    = SHA_TYPE;
                    elen     = 16'(HASH_LEN);
                    sha_used = 1'b1;
                end
                else
                begin
                    etype = 8'($urandom_range(0, 255));
                    if (etype == SHA_TYPE)
                        etype = ~SHA_TYPE;
                    elen = 16'($urandom_range(0, 4));
                end
                img_q.push_back(etype);
                put_rand(1);
                put_le(32'(elen), 2);
                if (!(etype == SHA_TYPE && elen != HASH_LEN))
                    put_rand(elen);
            end
            area = 16'(img_q.size() - info_pos);
            if (shape == IMG_SHORT_AREA)
                area = 16'($urandom_range(0, 4));
            if (shape == IMG_ODD_AREA)
                area = 16'($urandom_range(0, area + 8));
            img_q[info_pos + 2] = area[7:0];
            img_q[info_pos + 3] = area[15:8];
        end

        // bytes past the final status are dropped until the marked last one
        put_rand($urandom_range(0, 2));
        if (shape == IMG_TRUNCATED)
        begin
            cut = $urandom_range(1, img_q.size());
            while (img_q.size() > cut)
                void'(img_q.pop_back());
        end
    endtask

    // sender
    always @(posedge clk)
    begin : source_side
        img_beat_t nxt;
        if (rst_n)
        begin
            if (img.valid && img.ready)
            begin
                parse_byte(img.file_byte, img.last_byte);
                taken++;
            end
            calm <= (taken >= 200 && taken < 320);
            if (!img.valid || img.ready)
            begin
                if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    nxt = pending.pop_front();
                    img.valid     <= 1'b1;
                    img.file_byte <= nxt.data;
                    img.last_byte <= nxt.last;
                end
                else
                    img.valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin : sink_side
        res_t want;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: extra result beat, expected none, actual kind %0d %0d %0h",
                             $time, res.kind, res.status, res.hash_byte);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    seen++;
                    check_field("kind", want.kind, res.kind);
                    check_field("hash_byte", want.hash_byte, res.hash_byte);
                    check_field("hash_index", want.hash_index, res.hash_index);
                    check_field("status", want.status, res.status);
                    check_field("version_major", want.version_major, res.version_major);
                    check_field("version_minor", want.version_minor, res.version_minor);
                    check_field("version_revision", want.version_revision,
                                res.version_revision);
                    check_field("build_number", want.build_number, res.build_number);
                    check_field("image_size", want.image_size, res.image_size);
                    check_field("total_size", want.total_size, res.total_size);
                    check_field("run_last", want.run_last, res.run_last);
                    // back-pressure early in a hash, or once early on, so the buffer fills
                    if (holds_spare > 0
                        && ((want.kind == KIND_HASH && want.hash_index == 5'd2)
                            || (holds_spare == 2 && seen == 8)))
                    begin
                        hold_left = HOLD_CYCLES;
                        holds_spare--;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (img.valid && img.ready) || (res.valid && res.ready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         fed;
        int         shapes;
        int         pick;
        img_shape_t shape;
        img.valid     = 1'b0;
        img.file_byte = '0;
        img.last_byte = 1'b0;
        res.ready     = 1'b0;
        clear_model();

        // last byte alone
        push_beat(8'h00, 1'b1);
        // bad magic ending on the same byte
        push_beat(8'h3d, 1'b0);
        push_beat(8'hb8, 1'b0);
        push_beat(8'hf3, 1'b0);
        push_beat(8'h00, 1'b1);
        // bad magic, then ignored bytes
        repeat (4) push_beat(8'hff, 1'b0);
        push_beat(8'haa, 1'b0);
        push_beat(8'h55, 1'b0);
        push_beat(8'h00, 1'b1);
        // good magic, cut inside the header
        push_beat(8'h3d, 1'b0);
        push_beat(8'hb8, 1'b0);
        push_beat(8'hf3, 1'b0);
        push_beat(8'h96, 1'b0);
        repeat (3) push_beat(8'hff, 1'b0);
        push_beat(8'hff, 1'b1);

        fed    = 0;
        shapes = 0;
        while (fed < RAND_BYTES || shapes < IMG_SHAPES)
        begin
            if (shapes < IMG_SHAPES)
                shape = img_shape_t'(shapes);
            else
            begin
                pick = $urandom_range(0, IMG_SHAPES + 2);
                if (pick < IMG_SHAPES)
                    shape = img_shape_t'(pick);
                else
                    shape = IMG_OK;
            end
            shapes++;
            build_image(shape);
            fed += img_q.size();
            foreach (img_q[i])
                push_beat(img_q[i], i == img_q.size() - 1);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || img.valid)
            @(posedge clk);
        while (results_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/fwtlv_pkg.sv
rtl/fwtlv_in_if.sv
rtl/fwtlv_out_if.sv
rtl/fwtlv_parser.sv
rtl/fwtlv_res_fifo.sv
rtl/firmware_image_tlv_parser_top.sv
bench/firmware_image_tlv_parser_top_tb.sv
